FILE: hdl/unsigned_div_magic_number_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the unsigned division magic number block
// Shared property wrappers, clocked on clk_i, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_DIV_MAGIC_NUMBER_DEFINES_SVH
`define UNSIGNED_DIV_MAGIC_NUMBER_DEFINES_SVH

// cons must hold in the same cycle as ante
`define UDMN_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// cons must hold in the cycle after ante
`define UDMN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: hdl/udmn_pkg.sv
// ----------------------------------------------------------------------------
// udmn_pkg
// Types and constants for the unsigned division magic number block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package udmn_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ExpW   = 7;
  localparam int unsigned ShiftW = 6;
  localparam int unsigned CntW   = 5;

  typedef logic [WordW-1:0]  word_t;
  typedef logic [ExpW-1:0]   exp_t;
  typedef logic [ShiftW-1:0] shift_t;
  typedef logic [CntW-1:0]   cnt_t;

  localparam word_t  TwoPow31   = 32'h8000_0000;
  localparam word_t  TwoPow31M1 = 32'h7FFF_FFFF;
  localparam exp_t   ExpStart   = 7'd31;
  localparam exp_t   ExpLimit   = 7'd64;
  localparam exp_t   ShiftBias  = 7'd32;
  localparam shift_t MaxShift   = 6'd32;
  localparam cnt_t   CntLast    = 5'd31;

endpackage

`default_nettype wire

FILE: hdl/unsigned_div_magic_number.sv
// ----------------------------------------------------------------------------
// unsigned_div_magic_number
// Magic multiplier, add indicator and post-shift for unsigned 32-bit division
// by a constant divisor.
// ----------------------------------------------------------------------------
// Pulse start_i while busy_o is low to hand in a divisor. The result appears
// for exactly one cycle with done_o high and cannot be held off, so capture
// it then. One shared restoring divider produces one quotient bit per cycle
// and is run three times (for nc, for 2^31 / nc and for (2^31 - 1) /
// divisor), then the doubling loop takes one exponent step per cycle and
// ends with a final stop test. A zero divisor answers all zeros in the cycle
// after it is taken and never raises busy_o. start_i may be raised in the
// cycle that shows done_o.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module unsigned_div_magic_number (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire udmn_pkg::word_t  divisor_i,
  output logic                  done_o,
  output udmn_pkg::word_t       magic_multiplier_o,
  output logic                  add_indicator_o,
  output udmn_pkg::shift_t      post_shift_o
);

  import udmn_pkg::*;

  // sequencer states
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StNc   = 3'd1;  // (2^32 - d) mod d
  localparam logic [2:0] StQ1   = 3'd2;  // 2^31 / nc
  localparam logic [2:0] StQ2   = 3'd3;  // (2^31 - 1) / d
  localparam logic [2:0] StLoop = 3'd4;  // doubling steps

  // control state
  logic [2:0] state_q, state_d;
  logic       done_q, done_d;
  cnt_t       cnt_q, cnt_d;
  logic       first_q, first_d;

  // payload state
  word_t  d_q, d_d;
  word_t  nc_q, nc_d;
  word_t  div_num_q, div_num_d;
  word_t  div_den_q, div_den_d;
  word_t  div_rem_q, div_rem_d;
  word_t  div_quo_q, div_quo_d;
  word_t  q1_q, q1_d, r1_q, r1_d;
  word_t  q2_q, q2_d, r2_q, r2_d;
  exp_t   p_q, p_d;
  logic   add_q, add_d;
  word_t  mult_q, mult_d;
  logic   addo_q, addo_d;
  shift_t shift_q, shift_d;

  // divider datapath: one quotient bit a cycle
  logic [WordW:0] div_trial, div_diff;
  logic           div_ge;
  word_t          div_rem_nxt, div_quo_nxt;

  always_comb begin
    div_trial   = {div_rem_q, div_num_q[WordW-1]};
    div_diff    = div_trial - {1'b0, div_den_q};
    div_ge      = !div_diff[WordW];
    div_rem_nxt = div_ge ? div_diff[WordW-1:0] : div_trial[WordW-1:0];
    div_quo_nxt = {div_quo_q[WordW-2:0], div_ge};
  end

  // doubling step and stop test, all mod 2^32
  word_t r1_dbl, r2_dbl, r2_inc, nc_gap, d_gap, delta;
  logic  r1_ge, r2_ge, add_hit, go;
  word_t q1_step, r1_step, q2_step, r2_step;
  exp_t  exp_shift;

  always_comb begin
    r1_dbl  = {r1_q[WordW-2:0], 1'b0};
    r2_dbl  = {r2_q[WordW-2:0], 1'b0};
    r2_inc  = r2_q + 32'd1;
    nc_gap  = nc_q - r1_q;
    d_gap   = d_q - r2_q;
    r1_ge   = (r1_q >= nc_gap);
    r2_ge   = (r2_inc >= d_gap);
    q1_step = {q1_q[WordW-2:0], r1_ge};
    r1_step = r1_ge ? (r1_dbl - nc_q) : r1_dbl;
    q2_step = {q2_q[WordW-2:0], r2_ge};
    r2_step = r2_ge ? (r2_dbl + 32'd1 - d_q) : (r2_dbl + 32'd1);
    add_hit = r2_ge ? (q2_q >= TwoPow31M1) : (q2_q >= TwoPow31);
    // stop test on the registered values of the previous step
    delta   = d_q - 32'd1 - r2_q;
    go      = (p_q < ExpLimit) &&
              ((q1_q < delta) || ((q1_q == delta) && (r1_q == '0)));
    exp_shift = p_q - ShiftBias;
  end

  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    first_d   = first_q;
    d_d       = d_q;
    nc_d      = nc_q;
    div_num_d = div_num_q;
    div_den_d = div_den_q;
    div_rem_d = div_rem_q;
    div_quo_d = div_quo_q;
    q1_d      = q1_q;
    r1_d      = r1_q;
    q2_d      = q2_q;
    r2_d      = r2_q;
    p_d       = p_q;
    add_d     = add_q;
    mult_d    = mult_q;
    addo_d    = addo_q;
    shift_d   = shift_q;

    case (state_q)
      StIdle: begin
        if (start_i) begin
          d_d = divisor_i;
          if (divisor_i == '0) begin
            mult_d  = '0;
            addo_d  = 1'b0;
            shift_d = '0;
            done_d  = 1'b1;
          end else begin
            div_num_d = 32'd0 - divisor_i;
            div_den_d = divisor_i;
            div_rem_d = '0;
            cnt_d     = '0;
            state_d   = StNc;
          end
        end
      end
      StNc, StQ1, StQ2: begin
        div_num_d = {div_num_q[WordW-2:0], 1'b0};
        div_rem_d = div_rem_nxt;
        div_quo_d = div_quo_nxt;
        cnt_d     = cnt_q + 5'd1;
        if (cnt_q == CntLast) begin
          div_rem_d = '0;
          cnt_d     = '0;
          if (state_q == StNc) begin
            nc_d      = ~div_rem_nxt;
            div_num_d = TwoPow31;
            div_den_d = ~div_rem_nxt;
            state_d   = StQ1;
          end else if (state_q == StQ1) begin
            q1_d      = div_quo_nxt;
            r1_d      = div_rem_nxt;
            div_num_d = TwoPow31M1;
            div_den_d = d_q;
            state_d   = StQ2;
          end else begin
            q2_d    = div_quo_nxt;
            r2_d    = div_rem_nxt;
            p_d     = ExpStart;
            add_d   = 1'b0;
            first_d = 1'b1;
            state_d = StLoop;
          end
        end
      end
      StLoop: begin
        if (!first_q && !go) begin
          mult_d  = q2_q + 32'd1;
          addo_d  = add_q;
          shift_d = exp_shift[ShiftW-1:0];
          done_d  = 1'b1;
          state_d = StIdle;
        end else begin
          first_d = 1'b0;
          p_d     = p_q + 7'd1;
          q1_d    = q1_step;
          r1_d    = r1_step;
          q2_d    = q2_step;
          r2_d    = r2_step;
          add_d   = add_q | add_hit;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q       <= d_d;
    nc_q      <= nc_d;
    div_num_q <= div_num_d;
    div_den_q <= div_den_d;
    div_rem_q <= div_rem_d;
    div_quo_q <= div_quo_d;
    q1_q      <= q1_d;
    r1_q      <= r1_d;
    q2_q      <= q2_d;
    r2_q      <= r2_d;
    p_q       <= p_d;
    add_q     <= add_d;
    mult_q    <= mult_d;
    addo_q    <= addo_d;
    shift_q   <= shift_d;
  end

  assign busy_o             = (state_q != StIdle);
  assign done_o             = done_q;
  assign magic_multiplier_o = mult_q;
  assign add_indicator_o    = addo_q;
  assign post_shift_o       = shift_q;

endmodule

`default_nettype wire

FILE: hdl/udmn_chk.sv
// ----------------------------------------------------------------------------
// udmn_chk
// Port-level checks for the unsigned division magic number block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "unsigned_div_magic_number_defines.svh"

module udmn_chk (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start_i,
  input wire logic             busy_o,
  input wire udmn_pkg::word_t  divisor_i,
  input wire logic             done_o,
  input wire udmn_pkg::word_t  magic_multiplier_o,
  input wire logic             add_indicator_o,
  input wire udmn_pkg::shift_t post_shift_o
);

  import udmn_pkg::*;

  // nonzero divisor starts the sequencer
  `UDMN_ASSERT_NEXT(a_start_busy, start_i && !busy_o && (divisor_i != '0), busy_o)
  // zero divisor answers all zeros on the registered done_o
  `UDMN_ASSERT_NEXT(a_zero_div, start_i && !busy_o && (divisor_i == '0), done_o && (magic_multiplier_o == '0) && !add_indicator_o && (post_shift_o == '0))
  // busy drops exactly when the result shows
  `UDMN_ASSERT_SAME(a_fell_done, $fell(busy_o), done_o)
  `UDMN_ASSERT_SAME(a_done_idle, done_o, !busy_o && (post_shift_o <= MaxShift))

endmodule

bind unsigned_div_magic_number udmn_chk u_udmn_chk (.*);

`default_nettype wire
